// ----- hdl/cbz_pkg.sv -----
`timescale 1ns / 1ps

package cbz_pkg;

   localparam int COORD_BITS = 12;
   localparam int T_BITS     = 16;

   // s = 1 - t needs one more bit than t, because s reaches one when t is zero.
   localparam int S_BITS   = T_BITS + 1;
   localparam int SQ_BITS  = 2 * T_BITS + 1;
   localparam int W_BITS   = 3 * T_BITS + 1;
   localparam int C3_BITS  = COORD_BITS + 2;
   localparam int ACC_BITS = 3 * T_BITS + COORD_BITS;
   localparam int FRAC_SHIFT = 3 * T_BITS;

   typedef logic [W_BITS-1:0] weight_type;

   typedef struct packed {
      logic load1;
      logic load2;
   } cbz_load_type;

endpackage

// ----- hdl/cubic_bezier_point_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid, req_stall  req_ctrl_x0..3, req_ctrl_y0..3, req_t_frac
// rsp       out        rsp_valid, rsp_stall  rsp_pixel_x, rsp_pixel_y
//
// One request enters per clock while req_stall is low; results leave in request order.
// The five stages are: squares of t and s, cubic weights, coordinate products,
// pair sums, final sum and floor. Any stage holding no request takes a new one even
// while the result stage is stalled, so bubbles close up. Reset empties all stages.

module cubic_bezier_point_unit import cbz_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COORD_BITS-1:0]  req_ctrl_x0,
   input  logic [COORD_BITS-1:0]  req_ctrl_x1,
   input  logic [COORD_BITS-1:0]  req_ctrl_x2,
   input  logic [COORD_BITS-1:0]  req_ctrl_x3,
   input  logic [COORD_BITS-1:0]  req_ctrl_y0,
   input  logic [COORD_BITS-1:0]  req_ctrl_y1,
   input  logic [COORD_BITS-1:0]  req_ctrl_y2,
   input  logic [COORD_BITS-1:0]  req_ctrl_y3,
   input  logic [T_BITS-1:0]      req_t_frac,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_BITS-1:0]  rsp_pixel_x,
   output logic [COORD_BITS-1:0]  rsp_pixel_y
);

   localparam logic [W_BITS+1:0] WeightOne = (W_BITS+2)'(1) << FRAC_SHIFT;

   logic [5:1]                  load;
   logic [5:1]                  valid_ff;
   logic [5:1]                  valid_in;
   cbz_load_type                wload;
   weight_type                  weight_ff [4];

   logic [COORD_BITS-1:0]       req_coord [8];
   logic [C3_BITS-1:0]          coord_in  [8];
   logic [C3_BITS-1:0]          coord1_ff [8];
   logic [C3_BITS-1:0]          coord2_ff [8];
   logic [W_BITS+C3_BITS-1:0]   prod_full [8];
   logic [ACC_BITS-1:0]         prod_ff   [8];
   logic [ACC_BITS-1:0]         pair_in   [4];
   logic [ACC_BITS-1:0]         pair_ff   [4];
   logic [ACC_BITS-1:0]         sum_x;
   logic [ACC_BITS-1:0]         sum_y;
   logic [COORD_BITS-1:0]       pixel_x_ff;
   logic [COORD_BITS-1:0]       pixel_y_ff;
   logic [W_BITS+1:0]           weight_sum;

   // A stage may load when it is empty or when its contents move on.
   always_comb begin
      load[5] = !valid_ff[5] || !rsp_stall;
      for (int k = 4; k >= 1; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   assign req_stall   = !load[1];
   assign wload.load1 = load[1];
   assign wload.load2 = load[2];

   always_comb begin
      valid_in = valid_ff;
      if (load[1]) valid_in[1] = req_valid;
      for (int k = 2; k <= 5; k++) begin
         if (load[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   cbz_weights u_weights (
      .clock     (clock),
      .load      (wload),
      .t_frac    (req_t_frac),
      .weight_ff (weight_ff)
   );

   assign req_coord[0] = req_ctrl_x0;
   assign req_coord[1] = req_ctrl_x1;
   assign req_coord[2] = req_ctrl_x2;
   assign req_coord[3] = req_ctrl_x3;
   assign req_coord[4] = req_ctrl_y0;
   assign req_coord[5] = req_ctrl_y1;
   assign req_coord[6] = req_ctrl_y2;
   assign req_coord[7] = req_ctrl_y3;

   // The inner control points carry the Bernstein factor of three.
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         if (k == 1 || k == 2 || k == 5 || k == 6) begin
            coord_in[k] = C3_BITS'({req_coord[k], 1'b0}) + C3_BITS'(req_coord[k]);
         end else begin
            coord_in[k] = C3_BITS'(req_coord[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) coord1_ff <= coord_in;
      if (load[2]) coord2_ff <= coord1_ff;
   end

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         for (int j = 0; j < 4; j++) begin
            prod_full[c*4+j] = weight_ff[j] * coord2_ff[c*4+j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         for (int k = 0; k < 8; k++) begin
            prod_ff[k] <= prod_full[k][ACC_BITS-1:0];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pair_in[k] = prod_ff[2*k] + prod_ff[2*k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (load[4]) pair_ff <= pair_in;
   end

   // The weights sum to one, so the total never exceeds the largest control value.
   assign sum_x = pair_ff[0] + pair_ff[1];
   assign sum_y = pair_ff[2] + pair_ff[3];

   always_ff @(posedge clock) begin
      if (load[5]) begin
         pixel_x_ff <= sum_x[FRAC_SHIFT +: COORD_BITS];
         pixel_y_ff <= sum_y[FRAC_SHIFT +: COORD_BITS];
      end
   end

   assign rsp_valid   = valid_ff[5];
   assign rsp_pixel_x = pixel_x_ff;
   assign rsp_pixel_y = pixel_y_ff;

   assign weight_sum = {2'b00, weight_ff[0]} + {1'b0, weight_ff[1], 1'b0}
                     + {2'b00, weight_ff[1]} + {1'b0, weight_ff[2], 1'b0}
                     + {2'b00, weight_ff[2]} + {2'b00, weight_ff[3]};

   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> weight_sum == WeightOne)
      else $error("Bernstein weights do not sum to one");

   a_full_when_stalled: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (valid_ff == '1))
      else $error("request stalled while a stage is empty");

   a_hold_stage4: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[4] && !load[5]) |=> valid_ff[4])
      else $error("blocked stage four lost its request");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(valid_ff[4]))
      else $error("result appeared without a request behind it");

endmodule

// ----- hdl/cbz_weights.sv -----
`timescale 1ns / 1ps

module cbz_weights import cbz_pkg::*; (
   input  logic                clock,
   input  cbz_load_type        load,
   input  logic [T_BITS-1:0]   t_frac,
   output weight_type          weight_ff [4]
);

   logic [S_BITS-1:0]          s_in;
   logic [2*T_BITS-1:0]        tt_in;
   logic [2*S_BITS-1:0]        ss_full;
   logic [SQ_BITS-1:0]         ts_in;

   logic [T_BITS-1:0]          t_ff;
   logic [S_BITS-1:0]          s_ff;
   logic [2*T_BITS-1:0]        tt_ff;
   logic [SQ_BITS-1:0]         ss_ff;
   logic [SQ_BITS-1:0]         ts_ff;

   logic [SQ_BITS+S_BITS-1:0]  w0_full;
   logic [SQ_BITS+S_BITS-1:0]  w1_full;
   logic [W_BITS-1:0]          w2_in;
   logic [W_BITS-1:0]          w3_in;

   assign s_in    = {1'b1, {T_BITS{1'b0}}} - {1'b0, t_frac};
   assign tt_in   = t_frac * t_frac;
   assign ss_full = s_in * s_in;
   assign ts_in   = t_frac * s_in;

   always_ff @(posedge clock) begin
      if (load.load1) begin
         t_ff  <= t_frac;
         s_ff  <= s_in;
         tt_ff <= tt_in;
         ss_ff <= ss_full[SQ_BITS-1:0];
         ts_ff <= ts_in;
      end
   end

   // The factor three of the middle weights is applied to the coordinates instead.
   assign w0_full = ss_ff * s_ff;
   assign w1_full = ts_ff * s_ff;
   assign w2_in   = tt_ff * s_ff;
   assign w3_in   = tt_ff * t_ff;

   always_ff @(posedge clock) begin
      if (load.load2) begin
         weight_ff[0] <= w0_full[W_BITS-1:0];
         weight_ff[1] <= w1_full[W_BITS-1:0];
         weight_ff[2] <= w2_in;
         weight_ff[3] <= w3_in;
      end
   end

endmodule
